@@ src/rail_fence_transposer_macros.svh @@
// assertion macros for the rail fence transposer
// expects clk and rst_n in the scope of use; no other dependencies
`ifndef RAIL_FENCE_TRANSPOSER_MACROS_SVH
`define RAIL_FENCE_TRANSPOSER_MACROS_SVH

// condition holds at every clock edge out of reset
`define RFT_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define RFT_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define RFT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/rft_pkg.sv @@
// shared types and constants for the rail fence transposer
// no dependencies
package rft_pkg;

    localparam int MaxLength = 64;
    localparam int AddrW     = $clog2(MaxLength);
    localparam int CountW    = AddrW + 1;
    localparam int StepW     = CountW + 1;
    localparam int ApbAddrW  = 3;

    typedef logic [7:0]        byte_t;
    typedef logic [AddrW-1:0]  addr_t;
    typedef logic [CountW-1:0] count_t;

    typedef enum logic [3:0] {
        ST_LOAD  = 4'b0001,
        ST_PERM  = 4'b0010,
        ST_FLUSH = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    localparam logic REG_RAIL_COUNT = 1'b0;
    localparam logic REG_DIRECTION  = 1'b1;

endpackage

@@ src/rft_if.sv @@
// stream interfaces of the rail fence transposer: message in, transposed message out
// depends on rft_pkg
interface rft_in_if import rft_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface rft_out_if import rft_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  out_last;
    logic  truncated;

    modport source (output valid, output out_byte, output out_last, output truncated,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input truncated,
                    output ready);
endinterface

@@ src/rail_fence_transposer.sv @@
// rail fence transposer: buffers a message, permutes it over the rails, streams it out
// depends on rft_pkg, rft_if.sv and rail_fence_transposer_macros.svh
//
// a message of n bytes loads at one word per cycle while in the load state, is permuted
// by a shared add/compare zigzag walker followed by a flush state, then streams out at one
// word per cycle unless emit.ready holds the output back; a new message is taken only
// after the last word of the previous one has entered the registered output word
// reset clears control, rail_count to 2 and direction to 0; buffers are not cleared
`include "rail_fence_transposer_macros.svh"

module rail_fence_transposer import rft_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    rft_in_if.sink              load,
    rft_out_if.source           emit,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [6:0] rail_count_reg;
    logic       direction_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rail_count_reg <= 7'd2;
            direction_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_RAIL_COUNT: rail_count_reg <= pwdata[6:0];
                REG_DIRECTION:  direction_reg  <= pwdata[0];
                default:        rail_count_reg <= rail_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_RAIL_COUNT: prdata = {25'd0, rail_count_reg};
            REG_DIRECTION:  prdata = {31'd0, direction_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // control and walker state
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    count_t              count_reg, count_next;     // bytes stored so far
    logic                ovf_reg, ovf_next;         // a byte was dropped
    count_t              n_reg, n_next;             // length of the message in flight
    count_t              rails_reg, rails_next;     // saturated rail count
    logic [CountW-1:0]   period_reg, period_next;   // 2*(rails-1)
    logic                dir_reg, dir_next;
    logic                trunc_reg, trunc_next;
    addr_t               k_reg, k_next;             // slot index, then emit index
    addr_t               pos_reg, pos_next;         // message position of current slot
    addr_t               rail_reg, rail_next;
    logic                down_reg, down_next;       // next move heads down the fence
    logic                pend_reg, pend_next;       // buffer read in flight to perm memory
    addr_t               wa_reg, wa_next;
    logic                out_valid_reg, out_valid_next;

    byte_t               buf_rd_reg;
    byte_t               out_byte_reg;
    logic                out_last_reg;
    logic                out_trunc_reg;

    byte_t               msg_mem  [MaxLength];
    byte_t               perm_mem [MaxLength];

    logic                load_fire;
    logic                emit_fire;
    logic                k_done;
    logic                room;
    count_t              count_after;
    count_t              rails_sat;
    logic [CountW-1:0]   step;
    logic [StepW-1:0]    sum;
    logic                wrap;
    addr_t               last_rail;
    addr_t               rd_addr;
    addr_t               wr_addr;

    assign load.ready = (state_reg == ST_LOAD);
    assign load_fire  = load.valid && load.ready;
    assign room       = (count_reg < count_t'(MaxLength));
    assign k_done     = ((count_t'(k_reg) + count_t'(1)) == n_reg);
    assign emit_fire  = (state_reg == ST_EMIT) && (!out_valid_reg || emit.ready);

    assign count_after = room ? count_reg + count_t'(1) : count_reg;

    // rail count of zero is one rail; above the buffer depth it saturates
    always_comb
    begin
        priority if (rail_count_reg == 7'd0)
            rails_sat = count_t'(1);
        else if (count_t'(rail_count_reg) > count_t'(MaxLength))
            rails_sat = count_t'(MaxLength);
        else
            rails_sat = count_t'(rail_count_reg);
    end

    // shared zigzag unit: step along the current rail with a subtract, an add and a compare
    assign last_rail = addr_t'(rails_reg - count_t'(1));

    always_comb
    begin
        priority if (rails_reg == count_t'(1))
            step = CountW'(1);
        else if (rail_reg == addr_t'(0) || rail_reg == last_rail)
            step = period_reg;
        else if (down_reg)
            step = period_reg - {rail_reg, 1'b0};
        else
            step = {rail_reg, 1'b0};
    end

    assign sum  = StepW'(pos_reg) + StepW'(step);
    assign wrap = (sum >= StepW'(n_reg));

    // encrypt gathers by position into slot order, decrypt scatters slots to positions
    assign rd_addr = dir_reg ? k_reg : pos_reg;
    assign wr_addr = dir_reg ? pos_reg : k_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        rails_next     = rails_reg;
        period_next    = period_reg;
        dir_next       = dir_reg;
        trunc_next     = trunc_reg;
        k_next         = k_reg;
        pos_next       = pos_reg;
        rail_next      = rail_reg;
        down_next      = down_reg;
        pend_next      = 1'b0;
        wa_next        = wa_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && emit.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (load_fire)
                begin
                    count_next = count_after;
                    ovf_next   = ovf_reg || !room;
                    if (load.in_last)
                    begin
                        // sample config and start the permutation pass
                        n_next      = count_after;
                        trunc_next  = ovf_reg || !room;
                        rails_next  = rails_sat;
                        period_next = CountW'({rails_sat - count_t'(1), 1'b0});
                        dir_next    = direction_reg;
                        count_next  = '0;
                        ovf_next    = 1'b0;
                        k_next      = '0;
                        pos_next    = '0;
                        rail_next   = '0;
                        down_next   = 1'b1;
                        state_next  = ST_PERM;
                    end
                end
            end
            ST_PERM:
            begin
                pend_next = 1'b1;
                wa_next   = wr_addr;
                k_next    = k_reg + addr_t'(1);
                if (wrap)
                begin
                    // move to the head of the next rail
                    rail_next = rail_reg + addr_t'(1);
                    pos_next  = rail_reg + addr_t'(1);
                    down_next = 1'b1;
                end
                else
                begin
                    pos_next  = sum[AddrW-1:0];
                    down_next = !down_reg;
                end
                if (k_done)
                begin
                    k_next     = '0;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // last permuted word lands in perm memory this cycle
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next = 1'b1;
                    k_next         = k_reg + addr_t'(1);
                    if (k_done)
                    begin
                        k_next     = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            n_reg         <= count_t'(1);
            rails_reg     <= count_t'(1);
            period_reg    <= '0;
            dir_reg       <= 1'b0;
            trunc_reg     <= 1'b0;
            k_reg         <= '0;
            pos_reg       <= '0;
            rail_reg      <= '0;
            down_reg      <= 1'b1;
            pend_reg      <= 1'b0;
            wa_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            n_reg         <= n_next;
            rails_reg     <= rails_next;
            period_reg    <= period_next;
            dir_reg       <= dir_next;
            trunc_reg     <= trunc_next;
            k_reg         <= k_next;
            pos_reg       <= pos_next;
            rail_reg      <= rail_next;
            down_reg      <= down_next;
            pend_reg      <= pend_next;
            wa_reg        <= wa_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // message buffer: written while loading, read by the walker
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_fire && room)
            msg_mem[count_reg[AddrW-1:0]] <= load.in_byte;
        buf_rd_reg <= msg_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // permuted buffer: filled in the cycle after the walker visits each slot, read into the output word
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (pend_reg)
            perm_mem[wa_reg] <= buf_rd_reg;
        if (emit_fire)
        begin
            out_byte_reg  <= perm_mem[k_reg];
            out_last_reg  <= k_done;
            out_trunc_reg <= trunc_reg;
        end
    end

    assign emit.valid     = out_valid_reg;
    assign emit.out_byte  = out_byte_reg;
    assign emit.out_last  = out_last_reg;
    assign emit.truncated = out_trunc_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `RFT_ASSERT(a_count_range, count_reg <= count_t'(MaxLength), "byte count beyond depth")
    `RFT_ASSERT_IMPL(a_walk_in_range, state_reg == ST_PERM,
        (count_t'(k_reg) < n_reg) && (count_t'(pos_reg) < n_reg),
        "walker left the message")
    `RFT_ASSERT_IMPL(a_emit_after_flush, $rose(state_reg == ST_EMIT),
        $past(state_reg == ST_FLUSH), "emission started without flush")
    `RFT_ASSERT_NEXT(a_last_word_ends, emit_fire && k_done,
        out_valid_reg && out_last_reg && state_reg == ST_LOAD,
        "final word did not close the message")

endmodule
